### hw/rtl/token_bucket_io_throttle_assert.svh
// Assertion macros for the throttle RTL.
// Each macro expects clk and rst_n in scope.
`ifndef TOKEN_BUCKET_IO_THROTTLE_ASSERT_SVH
`define TOKEN_BUCKET_IO_THROTTLE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TBT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define TBT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TBT_ASSERT_IMP(lbl, ante, cons, msg)
`define TBT_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

### hw/rtl/tbt_pkg.sv
`default_nettype none
package tbt_pkg;

    localparam logic [31:0] LAT_RESET  = 32'hFFFFFF;
    localparam logic [13:0] TPS_RESET  = 14'd1000;
    localparam logic [63:0] REFILL_CAP = 64'h4000_0000_0000_0000;
    localparam int          DIV_STEPS  = 64;
    localparam int          CNT_W      = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        CMD_RESTART  = 3'd0,
        CMD_ACCOUNT  = 3'd1,
        CMD_OP       = 3'd2,
        CMD_PRECHG   = 3'd3,
        CMD_QUERY    = 3'd4
    } cmd_t;

    typedef enum logic [7:0] {
        REG_SPEED = 8'd0,
        REG_BURST = 8'd1,
        REG_LAT   = 8'd2,
        REG_TPS   = 8'd3
    } reg_idx_t;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_LOAD,
        DP_MUL,
        DP_STEP,
        DP_REFILL,
        DP_DEFMUL,
        DP_TICKS,
        DP_UNITS,
        DP_FIN
    } dp_op_t;

    typedef enum logic {
        DIV_BY_TPS,
        DIV_BY_SPEED
    } div_sel_t;

    typedef struct packed {
        dp_op_t   op;
        div_sel_t sel;
    } dp_cmd_t;

    typedef struct packed {
        logic need_charge;
        logic elapsed_pos;
        logic deficit_pos;
    } dp_stat_t;

endpackage
`default_nettype wire

### hw/rtl/tbt_if.sv
`default_nettype none
interface tbt_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [31:0] now_tick;
    logic [31:0] amount;
    logic        from_flusher;
    modport source (output valid, cmd, now_tick, amount, from_flusher, input ready);
    modport sink   (input valid, cmd, now_tick, amount, from_flusher, output ready);
endinterface

interface tbt_out_if;
    logic               valid;
    logic               ready;
    logic               status;
    logic [31:0]        wait_ticks;
    logic [63:0]        total_io;
    logic signed [47:0] bucket_level;
    modport source (output valid, status, wait_ticks, total_io, bucket_level, input ready);
    modport sink   (input valid, status, wait_ticks, total_io, bucket_level, output ready);
endinterface
`default_nettype wire

### hw/rtl/token_bucket_io_throttle.sv
// Channel  | Dir | Payload                                       | Handshake
// in_ch    | in  | cmd, now_tick, amount, from_flusher           | valid/ready
// out_ch   | out | status, wait_ticks, total_io, bucket_level    | valid/ready
// cfg      | in  | cfg_index, cfg_data                           | cfg_we only
//
// Restart, query and disabled items go from S_IDLE through S_CHECK to S_FIN,
// where the result is registered. A charge runs up to three 64-step divides on
// one shared restoring divider (refill, deficit ticks, units bought).
// Reset loads the register defaults and clears level, release time, remainder
// and total. A stalled result sits in the output register; the next item is
// taken meanwhile and waits at its final step until the register frees.
`default_nettype none
module token_bucket_io_throttle (
    input  wire logic  clk,
    input  wire logic  rst_n,
    tbt_in_if.sink     in_ch,
    tbt_out_if.source  out_ch,
    input  wire logic        cfg_we,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    // command and status between sequencer and datapath
    tbt_pkg::dp_cmd_t  dp_cmd;
    tbt_pkg::dp_stat_t dp_stat;

    // sequencer: owns the handshakes and steps the divider
    tbt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .dp_stat   (dp_stat),
        .dp_cmd    (dp_cmd)
    );

    // datapath: bucket state, config registers, multiplier and divider
    tbt_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (in_ch.cmd),
        .now_tick     (in_ch.now_tick),
        .amount       (in_ch.amount),
        .from_flusher (in_ch.from_flusher),
        .dp_cmd       (dp_cmd),
        .dp_stat      (dp_stat),
        .status       (out_ch.status),
        .wait_ticks   (out_ch.wait_ticks),
        .total_io     (out_ch.total_io),
        .bucket_level (out_ch.bucket_level)
    );

endmodule
`default_nettype wire

### hw/rtl/tbt_datapath.sv
`default_nettype none
module tbt_datapath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [7:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    input  wire logic [2:0]         cmd,
    input  wire logic [31:0]        now_tick,
    input  wire logic [31:0]        amount,
    input  wire logic               from_flusher,
    input  wire tbt_pkg::dp_cmd_t   dp_cmd,
    output tbt_pkg::dp_stat_t       dp_stat,
    output logic                    status,
    output logic [31:0]             wait_ticks,
    output logic [63:0]             total_io,
    output logic signed [47:0]      bucket_level
);

    logic [31:0] speed_reg, burst_reg, lat_reg;
    logic [13:0] tps_reg;

    logic [2:0]         cmd_reg;
    logic [31:0]        now_reg, amt_reg;
    logic               flush_reg;
    logic signed [63:0] lvl_reg, lvl_next;
    logic signed [47:0] credit_reg, credit_next;
    logic [31:0]        rel_reg, rel_next;
    logic [13:0]        frac_reg, frac_next;
    logic [63:0]        total_reg, total_next;
    logic [63:0]        prod_reg, prod_next;
    logic [63:0]        quo_reg, quo_next;
    logic [31:0]        rem_reg, rem_next;
    logic               status_reg;
    logic [31:0]        wait_reg, wait_next;
    logic [63:0]        tot_out_reg;
    logic signed [47:0] lvl_out_reg;

    logic               en;
    logic [31:0]        amt_c, rel_off, dvs;
    logic [63:0]        tps_e;
    logic signed [63:0] ceil_s, amt_s, sum_s, deficit;
    logic [63:0]        q_cl, ticks, off, units;
    logic [32:0]        r2;
    logic               ge;

    always_comb
    begin
        en      = speed_reg != 32'd0;
        amt_c   = (cmd_reg == tbt_pkg::CMD_OP) ? 32'd1 : amt_reg;
        tps_e   = {50'd0, (tps_reg == 14'd0) ? 14'd1 : tps_reg};
        rel_off = rel_reg - now_reg;
        dvs     = (dp_cmd.sel == tbt_pkg::DIV_BY_SPEED) ? speed_reg : tps_e[31:0];
        amt_s   = signed'({32'd0, amt_c});
        ceil_s  = signed'({31'd0, {1'b0, amt_c} + {1'b0, burst_reg}});
        deficit = amt_s - lvl_reg;
        q_cl    = (quo_reg > tbt_pkg::REFILL_CAP) ? tbt_pkg::REFILL_CAP : quo_reg;
        sum_s   = signed'(q_cl) + lvl_reg;
        ticks   = quo_reg + {63'd0, rem_reg != 32'd0};
        off     = {32'd0, rel_off} + ticks;
        units   = prod_reg + {32'd0, (rem_reg != 32'd0) ? speed_reg - rem_reg : 32'd0}
                  + {50'd0, frac_reg};
        r2      = {rem_reg, quo_reg[63]};
        ge      = r2 >= {1'b0, dvs};

        dp_stat.need_charge = en && (cmd_reg == tbt_pkg::CMD_ACCOUNT
                              || cmd_reg == tbt_pkg::CMD_OP || cmd_reg == tbt_pkg::CMD_PRECHG);
        dp_stat.elapsed_pos = rel_off[31];
        dp_stat.deficit_pos = amt_s > lvl_reg;

        lvl_next    = lvl_reg;
        credit_next = credit_reg;
        rel_next    = rel_reg;
        frac_next   = frac_reg;
        total_next  = total_reg;
        prod_next   = prod_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        wait_next   = 32'd0;

        case (dp_cmd.op)
            tbt_pkg::DP_LOAD:
            begin
                lvl_next = 64'(credit_reg);
            end
            tbt_pkg::DP_MUL:
            begin
                quo_next = {32'd0, speed_reg} * {32'd0, now_reg - rel_reg};
                rem_next = 32'd0;
            end
            tbt_pkg::DP_STEP:
            begin
                rem_next = ge ? 32'(r2 - {1'b0, dvs}) : r2[31:0];
                quo_next = {quo_reg[62:0], ge};
            end
            tbt_pkg::DP_REFILL:
            begin
                if (sum_s <= ceil_s)
                    lvl_next = sum_s;
                else if (lvl_reg < ceil_s)
                    lvl_next = ceil_s;
                rel_next = now_reg;
            end
            tbt_pkg::DP_DEFMUL:
            begin
                prod_next = {15'd0, deficit[48:0]} * tps_e[48:0];
                quo_next  = {15'd0, deficit[48:0]} * tps_e[48:0];
                rem_next  = 32'd0;
            end
            tbt_pkg::DP_TICKS:
            begin
                rel_next = now_reg + ((off > {32'd0, lat_reg}) ? lat_reg : off[31:0]);
                quo_next = units;
                rem_next = 32'd0;
            end
            tbt_pkg::DP_UNITS:
            begin
                frac_next = rem_reg[13:0];
                lvl_next  = lvl_reg + signed'(quo_reg);
            end
            tbt_pkg::DP_FIN:
            begin
                case (cmd_reg)
                    tbt_pkg::CMD_RESTART:
                    begin
                        credit_next = '0;
                        rel_next    = now_reg;
                    end
                    tbt_pkg::CMD_ACCOUNT:
                    begin
                        credit_next = en ? 48'(lvl_reg - amt_s) : credit_reg;
                        total_next  = total_reg + {32'd0, amt_reg};
                    end
                    tbt_pkg::CMD_OP:
                    begin
                        if (en && (lvl_reg > 64'sd1 || !flush_reg))
                            credit_next = 48'(lvl_reg - 64'sd1);
                        else
                            credit_next = lvl_reg[47:0];
                        total_next = total_reg + 64'd1;
                    end
                    tbt_pkg::CMD_PRECHG:
                    begin
                        credit_next = lvl_reg[47:0];
                    end
                    tbt_pkg::CMD_QUERY:
                    begin
                        if (en && !rel_off[31])
                            wait_next = (rel_off < lat_reg) ? rel_off : lat_reg;
                    end
                    default:
                    begin
                        credit_next = credit_reg;
                    end
                endcase
            end
            default:
            begin
                lvl_next = lvl_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg  <= '0;
            burst_reg  <= '0;
            lat_reg    <= tbt_pkg::LAT_RESET;
            tps_reg    <= tbt_pkg::TPS_RESET;
            credit_reg <= '0;
            rel_reg    <= '0;
            frac_reg   <= '0;
            total_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    tbt_pkg::REG_SPEED: speed_reg <= cfg_data;
                    tbt_pkg::REG_BURST: burst_reg <= cfg_data;
                    tbt_pkg::REG_LAT:   lat_reg   <= cfg_data;
                    tbt_pkg::REG_TPS:   tps_reg   <= cfg_data[13:0];
                    default:            speed_reg <= speed_reg;
                endcase
            end
            credit_reg <= credit_next;
            rel_reg    <= rel_next;
            frac_reg   <= frac_next;
            total_reg  <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.op == tbt_pkg::DP_LOAD)
        begin
            cmd_reg   <= cmd;
            now_reg   <= now_tick;
            amt_reg   <= amount;
            flush_reg <= from_flusher;
        end
        if (dp_cmd.op == tbt_pkg::DP_FIN)
        begin
            status_reg  <= !en;
            wait_reg    <= wait_next;
            tot_out_reg <= total_next;
            lvl_out_reg <= credit_next;
        end
        lvl_reg  <= lvl_next;
        prod_reg <= prod_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
    end

    assign status       = status_reg;
    assign wait_ticks   = wait_reg;
    assign total_io     = tot_out_reg;
    assign bucket_level = lvl_out_reg;

endmodule
`default_nettype wire

### hw/rtl/tbt_ctrl.sv
`default_nettype none
`include "token_bucket_io_throttle_assert.svh"
module tbt_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire tbt_pkg::dp_stat_t dp_stat,
    output tbt_pkg::dp_cmd_t       dp_cmd
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_CHECK = 10'b0000000010,
        S_DIV1  = 10'b0000000100,
        S_REFAP = 10'b0000001000,
        S_DEF   = 10'b0000010000,
        S_DIV2  = 10'b0000100000,
        S_TICKS = 10'b0001000000,
        S_DIV3  = 10'b0010000000,
        S_UNITS = 10'b0100000000,
        S_FIN   = 10'b1000000000
    } state_t;

    state_t                      state_reg, state_next;
    logic [tbt_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                        ov_reg, ov_next;
    logic                        last;

    assign last = cnt_reg == tbt_pkg::CNT_W'(tbt_pkg::DIV_STEPS - 1);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = '0;
        ov_next    = ov_reg && !out_ready;
        dp_cmd.op  = tbt_pkg::DP_NONE;
        dp_cmd.sel = tbt_pkg::DIV_BY_TPS;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    dp_cmd.op  = tbt_pkg::DP_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (dp_stat.need_charge && dp_stat.elapsed_pos)
                begin
                    dp_cmd.op  = tbt_pkg::DP_MUL;
                    state_next = S_DIV1;
                end
                else if (dp_stat.need_charge)
                    state_next = S_DEF;
                else
                    state_next = S_FIN;
            end
            S_DIV1, S_DIV2, S_DIV3:
            begin
                dp_cmd.op  = tbt_pkg::DP_STEP;
                dp_cmd.sel = (state_reg == S_DIV2) ? tbt_pkg::DIV_BY_SPEED
                                                   : tbt_pkg::DIV_BY_TPS;
                cnt_next   = cnt_reg + 1'b1;
                if (last)
                begin
                    case (state_reg)
                        S_DIV1:  state_next = S_REFAP;
                        S_DIV2:  state_next = S_TICKS;
                        default: state_next = S_UNITS;
                    endcase
                end
            end
            S_REFAP:
            begin
                dp_cmd.op  = tbt_pkg::DP_REFILL;
                state_next = S_DEF;
            end
            S_DEF:
            begin
                if (dp_stat.deficit_pos)
                begin
                    dp_cmd.op  = tbt_pkg::DP_DEFMUL;
                    state_next = S_DIV2;
                end
                else
                    state_next = S_FIN;
            end
            S_TICKS:
            begin
                dp_cmd.op  = tbt_pkg::DP_TICKS;
                state_next = S_DIV3;
            end
            S_UNITS:
            begin
                dp_cmd.op  = tbt_pkg::DP_UNITS;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                // hold until the output slot frees up
                if (!ov_reg || out_ready)
                begin
                    dp_cmd.op  = tbt_pkg::DP_FIN;
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = ov_reg;

    `TBT_ASSERT_NXT(a_accept_leaves_idle, in_valid && in_ready, state_reg == S_CHECK, "accept did not start item")
    `TBT_ASSERT_IMP(a_rise_after_fin, $rose(ov_reg), $past(state_reg) == S_FIN, "result without finish")
    `TBT_ASSERT_NXT(a_div_ends, (state_reg == S_DIV2) && last, state_reg == S_TICKS, "divide overran")

endmodule
`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    // Request as queued for the driver.
    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] now_tick;
        logic [31:0] amount;
        logic        from_flusher;
    } io_req_t;

    // Response the block should return for one request.
    typedef struct packed {
        logic               status;
        logic [31:0]        wait_ticks;
        logic [63:0]        total_io;
        logic signed [47:0] bucket_level;
    } io_resp_t;

    localparam longint CYCLE_LIMIT = 2000000;
    localparam int     DRAIN_CYCLES = 400;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [7:0]  cfg_index;
    logic [31:0] cfg_data;

    tbt_in_if  in_ch ();
    tbt_out_if out_ch ();

    token_bucket_io_throttle i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor shadow of the block: registers and bucket state.
    logic [31:0]        pr_speed;
    logic [31:0]        pr_burst;
    logic [31:0]        pr_latency;
    logic [13:0]        pr_tps;
    logic signed [47:0] pr_level;
    logic [31:0]        pr_release;
    logic [13:0]        pr_fraction;
    logic [63:0]        pr_total;

    io_req_t  pending_reqs[$];
    io_resp_t expected_resps[$];

    int     fail_count;
    longint cycle_count;
    bit     pressure_hold;   // receiver holds off while set, until hold_cycles runs out
    bit     idle_enable;     // random idling on both sides
    int     hold_cycles;
    int     sent_count;
    bit     sending;
    bit     in_accepted;     // item taken at the last rising edge

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("token_bucket_io_throttle regression: fail");
            $finish;
        end
    end

    // Refill and deficit handling of a charge; returns 1 when enabled.
    function automatic bit charge_bucket(input logic [31:0] amt, input logic [31:0] now);
        logic [63:0]        tps;
        logic signed [63:0] lvl;
        logic signed [63:0] ceiling;
        logic signed [63:0] sum;
        logic [63:0]        q;
        logic [63:0]        deficit;
        logic [63:0]        num;
        logic [63:0]        ticks;
        logic [63:0]        off;
        logic [63:0]        units;
        logic [31:0]        diff;
        tps = (pr_tps == 0) ? 64'd1 : {50'd0, pr_tps};
        if (pr_speed == 0)
            return 1'b0;
        lvl = 64'(pr_level);
        ceiling = $signed({32'd0, amt}) + $signed({32'd0, pr_burst});
        diff = pr_release - now;
        if (diff[31])
        begin
            q = ({32'd0, pr_speed} * {32'd0, now - pr_release}) / tps;
            if (q > tbt_pkg::REFILL_CAP)
                q = tbt_pkg::REFILL_CAP;
            sum = $signed(q) + lvl;
            if (sum <= ceiling)
                lvl = sum;
            else if (lvl < ceiling)
                lvl = ceiling;
            pr_release = now;
        end
        if ($signed({32'd0, amt}) > lvl)
        begin
            deficit = $signed({32'd0, amt}) - lvl;
            num = deficit * tps;
            ticks = num / pr_speed;
            if (num % pr_speed != 0)
                ticks = ticks + 1;
            off = {32'd0, pr_release - now} + ticks;
            if (off > {32'd0, pr_latency})
                off = {32'd0, pr_latency};
            pr_release = now + off[31:0];
            units = ticks * pr_speed + pr_fraction;
            pr_fraction = 14'(units % tps);
            lvl = lvl + $signed(units / tps);
        end
        pr_level = lvl[47:0];
        return 1'b1;
    endfunction

    function automatic io_resp_t predict_throttle(input io_req_t req);
        io_resp_t    resp;
        logic [31:0] d;
        resp.wait_ticks = '0;
        case (req.cmd)
            tbt_pkg::CMD_RESTART:
            begin
                pr_level = '0;
                pr_release = req.now_tick;
            end
            tbt_pkg::CMD_ACCOUNT:
            begin
                if (charge_bucket(req.amount, req.now_tick))
                    pr_level = pr_level - $signed({16'd0, req.amount});
                pr_total = pr_total + req.amount;
            end
            tbt_pkg::CMD_OP:
            begin
                if (charge_bucket(32'd1, req.now_tick))
                    if (pr_level > 1 || !req.from_flusher)
                        pr_level = pr_level - 1;
                pr_total = pr_total + 1;
            end
            tbt_pkg::CMD_PRECHG:
                void'(charge_bucket(req.amount, req.now_tick));
            tbt_pkg::CMD_QUERY:
            begin
                d = pr_release - req.now_tick;
                if (pr_speed != 0 && !d[31])
                    resp.wait_ticks = (d < pr_latency) ? d : pr_latency;
            end
            default:
            begin
            end
        endcase
        resp.status = (pr_speed == 0);
        resp.total_io = pr_total;
        resp.bucket_level = pr_level;
        return resp;
    endfunction

    // Driver: present queued items at the falling edge, hold until accepted.
    always @(negedge clk)
    begin
        if (!rst_n)
            in_ch.valid <= 1'b0;
        else if (in_ch.valid && !in_accepted)
        begin
            // hold the item until the block takes it
        end
        else if (pending_reqs.size() > 0 && sending
                 && !(idle_enable && $urandom_range(99) < 18))
        begin
            in_ch.valid <= 1'b1;
            {in_ch.cmd, in_ch.now_tick, in_ch.amount, in_ch.from_flusher}
                <= pending_reqs[0];
        end
        else
            in_ch.valid <= 1'b0;
    end

    // Pop and predict on the accepting edge.
    always @(posedge clk)
    begin
        in_accepted <= rst_n && in_ch.valid && in_ch.ready;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            expected_resps.push_back(predict_throttle(pending_reqs.pop_front()));
            sent_count <= sent_count + 1;
        end
    end

    // Receiver ready: random idling, plus a long hold counted here.
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (pressure_hold && hold_cycles < 1500)
        begin
            hold_cycles <= hold_cycles + 1;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= !(idle_enable && $urandom_range(99) < 18);
    end

    // Monitor: compare each result with the oldest expectation.
    always @(posedge clk)
    begin
        io_resp_t exp_r;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_resps.size() == 0)
            begin
                $error("result with no expectation waiting");
                fail_count = fail_count + 1;
            end
            else
            begin
                exp_r = expected_resps.pop_front();
                if (out_ch.status !== exp_r.status)
                begin
                    $error("status exp %0d got %0d", exp_r.status, out_ch.status);
                    fail_count = fail_count + 1;
                end
                if (out_ch.wait_ticks !== exp_r.wait_ticks)
                begin
                    $error("wait_ticks exp %0d got %0d", exp_r.wait_ticks,
                           out_ch.wait_ticks);
                    fail_count = fail_count + 1;
                end
                if (out_ch.total_io !== exp_r.total_io)
                begin
                    $error("total_io exp %0d got %0d", exp_r.total_io, out_ch.total_io);
                    fail_count = fail_count + 1;
                end
                if (out_ch.bucket_level !== exp_r.bucket_level)
                begin
                    $error("bucket_level exp %0d got %0d", exp_r.bucket_level,
                           out_ch.bucket_level);
                    fail_count = fail_count + 1;
                end
            end
        end
    end

    // Write one register at a falling edge; shadow it in the predictor.
    task automatic write_reg(input tbt_pkg::reg_idx_t idx, input logic [31:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            tbt_pkg::REG_SPEED: pr_speed = value;
            tbt_pkg::REG_BURST: pr_burst = value;
            tbt_pkg::REG_LAT:   pr_latency = value;
            tbt_pkg::REG_TPS:   pr_tps = value[13:0];
            default:
            begin
            end
        endcase
    endtask

    // Wait until queues drain, then for the charge latency.
    task automatic wait_idle();
        while (pending_reqs.size() > 0 || expected_resps.size() > 0 || in_ch.valid)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic queue_req(input logic [2:0] c, input logic [31:0] now,
                             input logic [31:0] amt, input logic fl);
        pending_reqs.push_back({c, now, amt, fl});
    endtask

    // Random phase: mostly plausible stream with advancing ticks, some noise.
    task automatic random_phase(input int count, inout logic [31:0] tick);
        int          pick;
        logic [31:0] amt;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            tick = tick + $urandom_range(0, 40);
            if (pick < 5)
                tick = $urandom;  // jump anywhere, including backwards
            case ($urandom_range(9))
                0, 1, 2: amt = $urandom_range(0, 64);
                3, 4:    amt = $urandom_range(0, 5000);
                5:       amt = $urandom;
                6:       amt = 32'hFFFF_FFFF;
                default: amt = $urandom_range(0, 400);
            endcase
            if (pick < 4)
                queue_req(3'($urandom_range(5, 7)), tick, amt, 1'($urandom));
            else if (pick < 10)
                queue_req(tbt_pkg::CMD_RESTART, tick, amt, 1'($urandom));
            else if (pick < 40)
                queue_req(tbt_pkg::CMD_ACCOUNT, tick, amt, 1'($urandom));
            else if (pick < 60)
                queue_req(tbt_pkg::CMD_OP, tick, amt, 1'($urandom));
            else if (pick < 75)
                queue_req(tbt_pkg::CMD_PRECHG, tick, amt, 1'($urandom));
            else
                queue_req(tbt_pkg::CMD_QUERY, tick, amt, 1'($urandom));
        end
    endtask

    initial
    begin
        logic [31:0] tick;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.cmd = '0;
        in_ch.now_tick = '0;
        in_ch.amount = '0;
        in_ch.from_flusher = 1'b0;
        out_ch.ready = 1'b0;
        fail_count = 0;
        cycle_count = 0;
        pressure_hold = 0;
        idle_enable = 1;
        hold_cycles = 0;
        sent_count = 0;
        sending = 1;
        in_accepted = 0;
        pr_speed = '0;
        pr_burst = '0;
        pr_latency = tbt_pkg::LAT_RESET;
        pr_tps = tbt_pkg::TPS_RESET;
        pr_level = '0;
        pr_release = '0;
        pr_fraction = '0;
        pr_total = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: disabled throttle first, then extremes of every field.
        queue_req(tbt_pkg::CMD_ACCOUNT, 32'd5, 32'hFFFF_FFFF, 1'b0);
        queue_req(tbt_pkg::CMD_QUERY, 32'd6, 32'd0, 1'b1);
        queue_req(3'd7, 32'hFFFF_FFFF, 32'd1, 1'b1);
        wait_idle();
        write_reg(tbt_pkg::REG_SPEED, 32'd1000);
        write_reg(tbt_pkg::REG_BURST, 32'd50);
        write_reg(tbt_pkg::REG_TPS, 32'd0);  // zero tick rate counts as one
        queue_req(tbt_pkg::CMD_RESTART, 32'd100, 32'd0, 1'b0);
        queue_req(tbt_pkg::CMD_ACCOUNT, 32'd100, 32'd5000, 1'b0);
        queue_req(tbt_pkg::CMD_QUERY, 32'd101, 32'd0, 1'b0);
        queue_req(tbt_pkg::CMD_OP, 32'd102, 32'd0, 1'b1);
        queue_req(tbt_pkg::CMD_OP, 32'd102, 32'd0, 1'b0);
        queue_req(tbt_pkg::CMD_PRECHG, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 1'b0);
        queue_req(tbt_pkg::CMD_QUERY, 32'h8000_0000, 32'd0, 1'b0);
        queue_req(3'd5, 32'd0, 32'd0, 1'b0);
        queue_req(3'd6, 32'd0, 32'd0, 1'b1);
        wait_idle();
        // Huge refill and wide ceiling: max speed and burst, long gap.
        write_reg(tbt_pkg::REG_SPEED, 32'hFFFF_FFFF);
        write_reg(tbt_pkg::REG_BURST, 32'hFFFF_FFFF);
        write_reg(tbt_pkg::REG_LAT, 32'hFFFF_FFFF);
        write_reg(tbt_pkg::REG_TPS, 32'd1);
        queue_req(tbt_pkg::CMD_RESTART, 32'd0, 32'd0, 1'b0);
        queue_req(tbt_pkg::CMD_PRECHG, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        queue_req(tbt_pkg::CMD_ACCOUNT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        queue_req(tbt_pkg::CMD_QUERY, 32'h7FFF_FFFF, 32'd0, 1'b0);
        wait_idle();
        // Slow refill, tight latency: deficit clamps and fraction carry.
        write_reg(tbt_pkg::REG_SPEED, 32'd1);
        write_reg(tbt_pkg::REG_BURST, 32'd0);
        write_reg(tbt_pkg::REG_LAT, 32'd0);
        write_reg(tbt_pkg::REG_TPS, 32'd10000);
        queue_req(tbt_pkg::CMD_RESTART, 32'd10, 32'd0, 1'b0);
        queue_req(tbt_pkg::CMD_ACCOUNT, 32'd10, 32'hFFFF_FFFF, 1'b0);
        queue_req(tbt_pkg::CMD_ACCOUNT, 32'd11, 32'hFFFF_FFFF, 1'b0);
        queue_req(tbt_pkg::CMD_QUERY, 32'd11, 32'd0, 1'b0);
        queue_req(tbt_pkg::CMD_OP, 32'd12, 32'd0, 1'b1);
        wait_idle();

        // Random phases over several settings.
        tick = $urandom;
        write_reg(tbt_pkg::REG_SPEED, 32'd1000);
        write_reg(tbt_pkg::REG_BURST, 32'd200);
        write_reg(tbt_pkg::REG_LAT, 32'd5000);
        write_reg(tbt_pkg::REG_TPS, 32'd1000);
        random_phase(250, tick);
        // Long receiver hold so the block backs up against its input.
        pressure_hold = 1;
        wait_idle();
        pressure_hold = 0;

        write_reg(tbt_pkg::REG_SPEED, $urandom_range(1, 100000));
        write_reg(tbt_pkg::REG_BURST, $urandom);
        write_reg(tbt_pkg::REG_LAT, $urandom_range(0, 300));
        write_reg(tbt_pkg::REG_TPS, 32'($urandom_range(1, 10000)));
        random_phase(200, tick);
        wait_idle();

        // Stretch with no idling at all.
        idle_enable = 0;
        write_reg(tbt_pkg::REG_SPEED, $urandom);
        write_reg(tbt_pkg::REG_BURST, $urandom_range(0, 20));
        write_reg(tbt_pkg::REG_LAT, tbt_pkg::LAT_RESET);
        write_reg(tbt_pkg::REG_TPS, 32'd10000);
        random_phase(200, tick);
        wait_idle();
        idle_enable = 1;

        write_reg(tbt_pkg::REG_SPEED, 32'd0);
        random_phase(50, tick);
        wait_idle();
        write_reg(tbt_pkg::REG_SPEED, 32'd7);
        write_reg(tbt_pkg::REG_BURST, 32'd3);
        write_reg(tbt_pkg::REG_LAT, 32'hFFFF_FFFF);
        write_reg(tbt_pkg::REG_TPS, 32'd1);
        random_phase(250, tick);

        wait_idle();
        if (fail_count == 0 && expected_resps.size() == 0)
            $display("token_bucket_io_throttle regression: pass");
        else
            $display("token_bucket_io_throttle regression: fail");
        $finish;
    end
endmodule
